[rtl/sv39ptw_pkg.sv]
`default_nettype none

package sv39ptw_pkg;

    localparam int unsigned TABLE_PAGES_DEF = 64;
    localparam int unsigned IDX_W           = 9;
    localparam int unsigned ENTRY_W         = 54;
    localparam int unsigned FRAME_W         = 44;
    localparam int unsigned FLAGS_W         = 10;
    localparam int unsigned VA_W            = 64;
    localparam int unsigned PA_W            = 56;
    localparam int unsigned PAGE_SHIFT      = 12;
    localparam int unsigned VPN_W           = 3 * IDX_W;

    localparam int unsigned FLAG_V_BIT = 0;
    localparam int unsigned FLAG_U_BIT = 4;
    localparam logic [FLAGS_W-1:0] FLAGS_V_ONLY = FLAGS_W'(1);

    typedef enum logic [1:0] {
        OP_TRANSLATE  = 2'd0,
        OP_MAP        = 2'd1,
        OP_UNMAP      = 2'd2,
        OP_CLEAR_USER = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_HIGH   = 3'd1,
        ST_NOT_USER   = 3'd2,
        ST_POOL_EMPTY = 3'd3,
        ST_ALREADY    = 3'd4,
        ST_MISALIGNED = 3'd5,
        ST_NO_ENTRY   = 3'd6,
        ST_NOT_LEAF   = 3'd7
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

`default_nettype wire

[rtl/sv39ptw_store.sv]
`default_nettype none

module sv39ptw_store #(
    parameter int unsigned TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sv39ptw_pkg::t_mem_ctl                i_ctl,
    input  wire logic [$clog2(TABLE_PAGES)+8:0]       i_addr,
    input  wire logic [sv39ptw_pkg::ENTRY_W-1:0]      i_wdata,
    output logic      [sv39ptw_pkg::ENTRY_W-1:0]      o_rdata,
    output logic                                      o_ready
);
    import sv39ptw_pkg::*;

    localparam int unsigned DEPTH = TABLE_PAGES * (2 ** IDX_W);
    localparam int unsigned AW    = $clog2(TABLE_PAGES) + IDX_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_clr_busy, n_clr_busy;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // zeroing sweep after reset, one entry per cycle
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign wr_en   = r_clr_busy || i_ctl.wr;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_addr;
    assign wr_data = r_clr_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clr_busy;

endmodule

`default_nettype wire

[rtl/sv39_page_table_walker_unit.sv]
`default_nettype none

// Sv39 page table walker over an internal table store of TABLE_PAGES pages
// of 512 entries. After reset the store is zeroed by a sweep over all
// TABLE_PAGES*512 entries (32768 by default) during which o_busy stays high.
// A request is taken when i_start is high and o_busy is low. Requests with a
// misaligned unmap address or an address at or above 2^38 finish in the
// accept cycle. All others read one table level per cycle from the single-port
// store, starting in the accept cycle, unless a map stalls to link a fresh
// table page for a missing entry. A full walk ends in the leaf step; a walk
// that stops at a missing or stray table entry finishes early. The result is
// presented for exactly one cycle with o_done the cycle after the request
// finishes; it cannot be held off, so capture it then. The next request may
// be started in that same cycle. Configuration writes are always ready and
// must only be issued while the unit is idle.
module sv39_page_table_walker_unit #(
    parameter int unsigned TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [sv39ptw_pkg::VA_W-1:0]        i_virt_addr,
    input  wire logic [sv39ptw_pkg::PA_W-1:0]        i_phys_addr,
    input  wire logic [sv39ptw_pkg::FLAGS_W-1:0]     i_perm_bits,
    output logic                                     o_done,
    output logic [2:0]                               o_status,
    output logic [sv39ptw_pkg::PA_W-1:0]             o_result_addr,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sv39ptw_pkg::FRAME_W-1:0]     i_table_base_frame
);
    import sv39ptw_pkg::*;

    localparam int unsigned SW = $clog2(TABLE_PAGES);
    localparam int unsigned AW = SW + IDX_W;
    localparam int unsigned NW = $clog2(TABLE_PAGES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_LEAF  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [VPN_W-1:0]   r_vpn, n_vpn;
    logic [FRAME_W-1:0] r_pframe, n_pframe;
    logic [FLAGS_W-1:0] r_perm, n_perm;
    logic               r_lvl2, n_lvl2;
    logic [SW-1:0]      r_slot, n_slot;
    logic [AW-1:0]      r_addr, n_addr;
    logic [NW-1:0]      r_next_free, n_next_free;
    logic [FRAME_W-1:0] r_base;
    logic               r_done, n_done;
    t_status            r_status, n_status;
    logic [PA_W-1:0]    r_result, n_result;

    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] e;
    logic               store_ready;
    logic               accept;
    logic [FRAME_W-1:0] off;
    logic               off_bad;
    logic [IDX_W-1:0]   next_idx;
    t_status            walk_fail;

    sv39ptw_store #(
        .TABLE_PAGES(TABLE_PAGES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (e),
        .o_ready (store_ready)
    );

    assign o_busy      = (r_state != S_IDLE) || !store_ready;
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    assign off       = e[ENTRY_W-1:FLAGS_W] - r_base;
    assign off_bad   = off >= FRAME_W'(TABLE_PAGES);
    assign next_idx  = r_lvl2 ? r_vpn[2*IDX_W-1:IDX_W] : r_vpn[IDX_W-1:0];
    assign walk_fail = (r_op == OP_TRANSLATE) ? ST_NOT_USER : ST_NO_ENTRY;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_vpn       = r_vpn;
        n_pframe    = r_pframe;
        n_perm      = r_perm;
        n_lvl2      = r_lvl2;
        n_slot      = r_slot;
        n_addr      = r_addr;
        n_next_free = r_next_free;
        n_done      = 1'b0;
        n_status    = r_status;
        n_result    = r_result;
        mem_ctl     = '0;
        mem_addr    = r_addr;
        mem_wdata   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_operation);
                    n_vpn    = i_virt_addr[PAGE_SHIFT+VPN_W-1:PAGE_SHIFT];
                    n_pframe = i_phys_addr[PA_W-1:PAGE_SHIFT];
                    n_perm   = i_perm_bits;
                    n_lvl2   = 1'b1;
                    n_result = '0;
                    if (i_operation == OP_UNMAP && |i_virt_addr[PAGE_SHIFT-1:0]) begin
                        n_done   = 1'b1;
                        n_status = ST_MISALIGNED;
                    end else if (|i_virt_addr[VA_W-1:PAGE_SHIFT+VPN_W-1]) begin
                        n_done   = 1'b1;
                        n_status = ST_TOO_HIGH;
                    end else begin
                        mem_ctl.rd = 1'b1;
                        mem_addr   = {SW'(0),
                                      i_virt_addr[PAGE_SHIFT+VPN_W-1:PAGE_SHIFT+2*IDX_W]};
                        n_addr     = mem_addr;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (e[FLAG_V_BIT]) begin
                    if (off_bad) begin
                        n_done   = 1'b1;
                        n_status = walk_fail;
                        n_state  = S_IDLE;
                    end else begin
                        mem_ctl.rd = 1'b1;
                        mem_addr   = {off[SW-1:0], next_idx};
                        n_addr     = mem_addr;
                        n_state    = r_lvl2 ? S_WALK : S_LEAF;
                        n_lvl2     = 1'b0;
                    end
                end else if (r_op != OP_MAP) begin
                    n_done   = 1'b1;
                    n_status = walk_fail;
                    n_state  = S_IDLE;
                end else if (r_next_free >= NW'(TABLE_PAGES)) begin
                    n_done   = 1'b1;
                    n_status = ST_POOL_EMPTY;
                    n_state  = S_IDLE;
                end else begin
                    // link a fresh table page
                    mem_ctl.wr  = 1'b1;
                    mem_wdata   = {r_base + FRAME_W'(r_next_free), FLAGS_V_ONLY};
                    n_slot      = r_next_free[SW-1:0];
                    n_next_free = r_next_free + NW'(1);
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                mem_ctl.rd = 1'b1;
                mem_addr   = {r_slot, next_idx};
                n_addr     = mem_addr;
                n_state    = r_lvl2 ? S_WALK : S_LEAF;
                n_lvl2     = 1'b0;
            end
            S_LEAF: begin
                n_done   = 1'b1;
                n_state  = S_IDLE;
                n_status = ST_OK;
                n_result = '0;
                case (r_op)
                    OP_TRANSLATE: begin
                        if (!e[FLAG_V_BIT] || !e[FLAG_U_BIT]) begin
                            n_status = ST_NOT_USER;
                        end else begin
                            n_result = {e[ENTRY_W-1:FLAGS_W], PAGE_SHIFT'(0)};
                        end
                    end
                    OP_MAP: begin
                        if (e[FLAG_V_BIT]) begin
                            n_status = ST_ALREADY;
                        end else begin
                            mem_ctl.wr = 1'b1;
                            mem_wdata  = {r_pframe, r_perm[FLAGS_W-1:1], 1'b1};
                        end
                    end
                    OP_UNMAP: begin
                        if (!e[FLAG_V_BIT]) begin
                            n_status = ST_NO_ENTRY;
                        end else if (e[FLAGS_W-1:0] == FLAGS_V_ONLY) begin
                            n_status = ST_NOT_LEAF;
                        end else begin
                            n_result   = {e[ENTRY_W-1:FLAGS_W], PAGE_SHIFT'(0)};
                            mem_ctl.wr = 1'b1;
                            mem_wdata  = '0;
                        end
                    end
                    OP_CLEAR_USER: begin
                        mem_ctl.wr = 1'b1;
                        mem_wdata  = e;
                        mem_wdata[FLAG_U_BIT] = 1'b0;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= NW'(1);
            r_base      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_done      <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_table_base_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_vpn    <= n_vpn;
        r_pframe <= n_pframe;
        r_perm   <= n_perm;
        r_lvl2   <= n_lvl2;
        r_slot   <= n_slot;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_result_addr = r_result;

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE) || o_done)
        else $error("accepted request neither walking nor answered");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= NW'(1)) && (r_next_free <= NW'(TABLE_PAGES)))
        else $error("table pool counter out of range");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.rd && mem_ctl.wr))
        else $error("store read and write issued together");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_state == S_LEAF || r_state == S_WALK || accept))
        else $error("result strobe without a request");

    a_alloc_map_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != $past(r_next_free)) |-> $past(r_op == OP_MAP && r_state == S_WALK))
        else $error("table page taken outside a map walk");

endmodule

`default_nettype wire
